/* hdl/assert_macros.svh */
// Assertion helper macros for the contrast ratio block.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge, masked during reset.
`define WCR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define WCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/wcr_pkg.sv */
// Shared constants and the sRGB linearization entry function.
// Used by wcr_luma, wcr_div and the top level; no dependencies.
package wcr_pkg;

  localparam int LIN_FRAC_BITS_DEF = 24;
  localparam int CODE_W = 8;
  localparam int RATIO_W = 12;
  localparam int WEIGHT_W = 16;
  localparam int QUOT_BITS = 12;
  localparam int LIN_LAST_CODE = 10;

  localparam logic [WEIGHT_W-1:0] WEIGHT_R = 16'd13933;
  localparam logic [WEIGHT_W-1:0] WEIGHT_G = 16'd46871;
  localparam logic [WEIGHT_W-1:0] WEIGHT_B = 16'd4732;

  function automatic logic [511:0] pow5(logic [511:0] t);
    return t * t * t * t * t;
  endfunction

  // Linear light value of one 8-bit code, rounded to frac fractional bits.
  function automatic longint unsigned lin_entry(int code, int frac);
    real s;
    real v;
    longint unsigned scaled;
    longint unsigned res;
    logic [511:0] p;
    logic [511:0] d;
    if (code <= LIN_LAST_CODE) begin
      scaled = longint'(code * 10) << frac;
      res = (2 * scaled + 64'd32946) / 64'd65892;
    end else begin
      s = (code * 1000.0 + 14025.0) / 269025.0;
      v = (s ** 2.4) * (2.0 ** frac);
      res = longint'(v);
      // Settle the rounding exactly: (res-1/2)^5 <= s^12 * 2^(5*frac) < (res+1/2)^5
      p = 512'(1);
      d = 512'(1);
      for (int k = 0; k < 12; k++) begin
        p = p * 512'(code * 1000 + 14025);
        d = d * 512'(269025);
      end
      p = p << (5 * frac + 5);
      while (pow5(512'(2 * res + 1)) * d <= p) res++;
      while (pow5(512'(2 * res - 1)) * d > p) res--;
    end
    return res;
  endfunction

endpackage

/* hdl/wcag_contrast_ratio_core.sv */
// Channel  Dir  Handshake          Payload
// s_axis   in   s_tvalid/s_tready  s_tdata: six 8-bit sRGB codes
// m_axis   out  m_tvalid/m_tready  m_tdata: ratio_centi, 12 bits
// One item per cycle while m_tready does not stall the output; stages: 3 luminance, 2 ratio setup, 12 divide.
// The divider retires one quotient bit per stage, which sets the depth.
// rst is synchronous, active high, and clears the valid bits only.
// A stall on m_tready freezes every stage; s_tready follows it.
`include "assert_macros.svh"
module wcag_contrast_ratio_core #(
  parameter int LIN_FRAC_BITS = wcr_pkg::LIN_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // [7:0] first_red, [15:8] first_green, [23:16] first_blue,
  // [31:24] second_red, [39:32] second_green, [47:40] second_blue
  input  logic [47:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // [11:0] ratio_centi, [15:12] zero
  output logic [15:0] m_tdata
);

  logic en;
  logic [wcr_pkg::CODE_W-1:0] codes [6];
  logic lvld;
  logic [LIN_FRAC_BITS+16:0] luma_a;
  logic [LIN_FRAC_BITS+16:0] luma_b;
  logic [wcr_pkg::RATIO_W-1:0] ratio;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  for (genvar k = 0; k < 6; k++) begin : g_codes
    assign codes[k] = s_tdata[8*k +: 8];
  end

  wcr_luma #(.LIN_FRAC_BITS(LIN_FRAC_BITS)) u_luma (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid), .codes(codes),
    .out_valid(lvld), .luma_a(luma_a), .luma_b(luma_b)
  );

  wcr_div #(.LIN_FRAC_BITS(LIN_FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(lvld), .luma_a(luma_a),
    .luma_b(luma_b), .out_valid(m_tvalid), .ratio(ratio)
  );

  assign m_tdata = {4'b0, ratio};

  `WCR_ASSERT_IMPL(a_range, clk, rst, m_tvalid, (ratio >= 12'd100) && (ratio <= 12'd2100), "ratio out of range")
  `WCR_ASSERT_IMPL(a_ready, clk, rst, !s_tready, m_tvalid && !m_tready, "ready dropped without stall")
  `WCR_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(ratio), "result lost in stall")

endmodule

/* hdl/wcr_luma.sv */
// Luminance pipeline: ROM lookup, weighted products, sums for both colors.
// Depends on wcr_pkg.
module wcr_luma #(
  parameter int LIN_FRAC_BITS = wcr_pkg::LIN_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [wcr_pkg::CODE_W-1:0] codes [6],
  output logic out_valid,
  output logic [LIN_FRAC_BITS+16:0] luma_a,
  output logic [LIN_FRAC_BITS+16:0] luma_b
);

  localparam int LINW = LIN_FRAC_BITS + 1;
  localparam int LW = LIN_FRAC_BITS + 17;

  typedef logic [LINW-1:0] rom_t [256];

  function automatic rom_t build_rom();
    rom_t r;
    for (int c = 0; c < 256; c++) begin
      r[c] = LINW'(wcr_pkg::lin_entry(c, LIN_FRAC_BITS));
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [LINW-1:0] lin [6];
  logic [LW-1:0] prod [6];
  logic [2:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        lin[k] <= ROM[codes[k]];
      end
      for (int c = 0; c < 2; c++) begin
        prod[3*c]   <= LW'(wcr_pkg::WEIGHT_R * lin[3*c]);
        prod[3*c+1] <= LW'(wcr_pkg::WEIGHT_G * lin[3*c+1]);
        prod[3*c+2] <= LW'(wcr_pkg::WEIGHT_B * lin[3*c+2]);
      end
      luma_a <= prod[0] + prod[1] + prod[2];
      luma_b <= prod[3] + prod[4] + prod[5];
    end
  end

  assign out_valid = vld[2];

endmodule

/* hdl/wcr_div.sv */
// Ratio pipeline: order, offset, scale, then restoring division one bit a stage.
// Depends on wcr_pkg.
module wcr_div #(
  parameter int LIN_FRAC_BITS = wcr_pkg::LIN_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [LIN_FRAC_BITS+16:0] luma_a,
  input  logic [LIN_FRAC_BITS+16:0] luma_b,
  output logic out_valid,
  output logic [wcr_pkg::RATIO_W-1:0] ratio
);

  localparam int NB = wcr_pkg::QUOT_BITS;
  localparam int NW = LIN_FRAC_BITS + 21;
  localparam int RW = LIN_FRAC_BITS + 30;
  localparam int CW = LIN_FRAC_BITS + 34;
  localparam logic [NW-1:0] ONE = NW'(1) << (LIN_FRAC_BITS + 16);

  logic [NW-1:0] num;
  logic [NW-1:0] den;
  // [0] num/den stage, [1] dividend stage, [k+2] after quotient bit k
  logic [NB+1:0] vld;
  logic [RW-1:0] rem [NB+1];
  logic [RW-1:0] dv [NB+1];
  logic [NB-1:0] quo [NB+1];
  logic [CW-1:0] shifted [NB];
  logic [NB-1:0] take;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NB:0], in_valid};
    end
  end

  always_comb begin
    for (int k = 0; k < NB; k++) begin
      shifted[k] = CW'(dv[k]) << (NB - 1 - k);
      take[k] = CW'(rem[k]) >= shifted[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (luma_a > luma_b) begin
        num <= NW'(luma_a) * NW'(20) + ONE;
        den <= NW'(luma_b) * NW'(20) + ONE;
      end else begin
        num <= NW'(luma_b) * NW'(20) + ONE;
        den <= NW'(luma_a) * NW'(20) + ONE;
      end
      // dividend 200*num + den, divisor 2*den: rounds half up
      rem[0] <= RW'(num) * RW'(200) + RW'(den);
      dv[0]  <= RW'(den) << 1;
      quo[0] <= '0;
      for (int k = 0; k < NB; k++) begin
        rem[k+1] <= take[k] ? RW'(CW'(rem[k]) - shifted[k]) : rem[k];
        dv[k+1]  <= dv[k];
        quo[k+1] <= quo[k] | (NB'(take[k]) << (NB - 1 - k));
      end
    end
  end

  assign out_valid = vld[NB+1];
  assign ratio = quo[NB];

endmodule

/* bench/tb.sv */
// Testbench for wcag_contrast_ratio_core: directed color pairs, then random pairs.
// Depends on wcr_pkg for widths and weights; contrast ratios are predicted in-bench from exact linear table values.
`timescale 1ns / 100ps
module tb;

  localparam int FRAC = wcr_pkg::LIN_FRAC_BITS_DEF;
  localparam int RATIO_W = wcr_pkg::RATIO_W;
  localparam int LIN_LAST_CODE = wcr_pkg::LIN_LAST_CODE;
  localparam int DIRECTED = 14;
  localparam int RANDOM_ITEMS = 1850;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [47:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [15:0] m_tdata;

  wcag_contrast_ratio_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  longint unsigned lin_tab[256];
  logic [RATIO_W-1:0] ratio_q[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  bit sender_done = 0;
  bit hold_req = 0;
  bit no_idle = 0;

  logic [47:0] dir_pair[DIRECTED];
  int dir_want[DIRECTED];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [511:0] fifth(logic [511:0] t);
    return t * t * t * t * t;
  endfunction

  // Round-to-nearest of the sRGB transfer value at FRAC bits, settled exactly.
  function automatic longint unsigned srgb_linear(int code);
    logic [511:0] p;
    logic [511:0] d;
    longint unsigned c;
    real x;
    longint unsigned scaled;
    if (code <= LIN_LAST_CODE) begin
      scaled = longint'(code * 10) << FRAC;
      return (2 * scaled + 64'd32946) / 64'd65892;
    end
    x = (((code * 1000.0 + 14025.0) / 269025.0) ** 2.4) * (2.0 ** FRAC);
    c = longint'($floor(x + 0.5));
    p = 1;
    d = 1;
    for (int k = 0; k < 12; k++) begin
      p = p * (code * 1000 + 14025);
      d = d * 269025;
    end
    p = p << (5 * FRAC + 5);
    while (fifth(512'(2 * c + 1)) * d <= p) c++;
    while (fifth(512'(2 * c - 1)) * d > p) c--;
    return c;
  endfunction

  function automatic longint unsigned luminance(logic [23:0] rgb);
    return longint'(wcr_pkg::WEIGHT_R) * lin_tab[rgb[7:0]] +
           longint'(wcr_pkg::WEIGHT_G) * lin_tab[rgb[15:8]] +
           longint'(wcr_pkg::WEIGHT_B) * lin_tab[rgb[23:16]];
  endfunction

  function automatic logic [RATIO_W-1:0] contrast_centi(logic [47:0] pair);
    longint unsigned la, lb, hi, lo, one, num, den;
    la = luminance(pair[23:0]);
    lb = luminance(pair[47:24]);
    hi = (la > lb) ? la : lb;
    lo = (la > lb) ? lb : la;
    one = 64'd1 << (FRAC + 16);
    num = 20 * hi + one;
    den = 20 * lo + one;
    return RATIO_W'((200 * num + den) / (2 * den));
  endfunction

  function automatic logic [23:0] rand_color();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: begin
        logic [7:0] g;
        g = $urandom_range(0, 255);
        return {g, g, g};
      end
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] rand_pair();
    logic [23:0] a;
    logic [23:0] b;
    a = rand_color();
    case ($urandom_range(0, 3))
      0: b = a;
      1: b = a ^ 24'($urandom_range(0, 7));
      default: b = rand_color();
    endcase
    return {b, a};
  endfunction

  // Sender
  task automatic offer(logic [47:0] pair);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pair;
    ratio_q.push_back(contrast_centi(pair));
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  initial begin
    int idx;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    for (int c = 0; c < 256; c++) lin_tab[c] = srgb_linear(c);
    // table rows: pair {second, first}; -1 means use the predictor
    dir_pair[0] = {24'hFFFFFF, 24'h000000}; dir_want[0] = 2100;
    dir_pair[1] = {24'h000000, 24'hFFFFFF}; dir_want[1] = 2100;
    dir_pair[2] = {24'h000000, 24'h000000}; dir_want[2] = 100;
    dir_pair[3] = {24'hFFFFFF, 24'hFFFFFF}; dir_want[3] = 100;
    dir_pair[4] = {24'h808080, 24'h808080}; dir_want[4] = 100;
    dir_pair[5] = {24'h0000FF, 24'h000000}; dir_want[5] = -1;
    dir_pair[6] = {24'h00FF00, 24'h000000}; dir_want[6] = -1;
    dir_pair[7] = {24'hFF0000, 24'h000000}; dir_want[7] = -1;
    dir_pair[8] = {24'hFFFFFF, 24'h0A0A0A}; dir_want[8] = -1;
    dir_pair[9] = {24'hFFFFFF, 24'h0B0B0B}; dir_want[9] = -1;
    dir_pair[10] = {24'h0B0B0B, 24'hFFFFFF}; dir_want[10] = -1;
    dir_pair[11] = {24'h010101, 24'h000000}; dir_want[11] = -1;
    dir_pair[12] = {24'hFEFEFE, 24'hFFFFFF}; dir_want[12] = -1;
    dir_pair[13] = {24'h123456, 24'h654321}; dir_want[13] = -1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (idx = 0; idx < DIRECTED; idx++) begin
      if (dir_want[idx] >= 0 && contrast_centi(dir_pair[idx]) != dir_want[idx]) begin
        $display("%0t predictor row %0d: expected %0d actual %0d", $time, idx,
                 dir_want[idx], contrast_centi(dir_pair[idx]));
        errors++;
      end
      offer(dir_pair[idx]);
    end
    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      no_idle = (idx >= 1000 && idx < 1200);
      if (idx == 500) hold_req = 1'b1;
      offer(rand_pair());
    end
    s_tvalid <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      received++;
      if (ratio_q.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, m_tdata);
        errors++;
      end else begin
        logic [RATIO_W-1:0] want;
        want = ratio_q.pop_front();
        if (m_tdata[RATIO_W-1:0] !== want) begin
          $display("%0t ratio_centi: expected %0d actual %0d", $time, want,
                   m_tdata[RATIO_W-1:0]);
          errors++;
        end
        if (m_tdata[15:RATIO_W] !== '0) begin
          $display("%0t pad bits: expected 0 actual %h", $time, m_tdata[15:RATIO_W]);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item on either side
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("%0t timeout, %0d results outstanding", $time, ratio_q.size());
        $display("FAIL wcag_contrast_ratio_core");
        $finish;
      end
    end
  end

  initial begin
    wait (sender_done);
    while (ratio_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d color pairs (directed extremes, then random), checked %0d ratios,",
             sent, received);
    $display("with random idling on both sides, a long output stall and a no-idle burst.");
    if (errors == 0) begin
      $display("PASS wcag_contrast_ratio_core");
    end else begin
      $display("FAIL wcag_contrast_ratio_core");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/wcr_pkg.sv
hdl/wcr_luma.sv
hdl/wcr_div.sv
hdl/wcag_contrast_ratio_core.sv
bench/tb.sv
